>>> sv/pairwise_category_cooccurrence_counter_top_defines.svh
// Assertion macros for the pairwise category co-occurrence counter.
`ifndef PAIRWISE_CATEGORY_COOCCURRENCE_COUNTER_TOP_DEFINES_SVH
`define PAIRWISE_CATEGORY_COOCCURRENCE_COUNTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define PCCC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error(msg);

`define PCCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PCCC_ASSERT_IMP(label, clk, rst, ante, cons, msg)

`define PCCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> sv/pccc_pkg.sv
// Shared constants, types and helper functions of the co-occurrence counter.
package pccc_pkg;

  localparam int MAX_CATEGORIES = 8;
  localparam int MAX_TIMES      = 8;
  localparam int COUNT_BITS     = 24;

  localparam int MAX_PAIRS  = MAX_TIMES * (MAX_TIMES - 1) / 2;
  localparam int TABLE_SIZE = MAX_CATEGORIES * MAX_CATEGORIES * MAX_PAIRS;

  localparam int ADDR_W       = $clog2(TABLE_SIZE);
  localparam int PAIR_W       = $clog2(MAX_PAIRS + 1);
  localparam int TIME_IDX_W   = $clog2(MAX_TIMES);
  localparam int VAL_W        = 5;
  localparam int CFG_W        = 4;
  localparam int CAT_FIELD_W  = 4;
  localparam int TIME_FIELD_W = 4;
  localparam int PAIR_FIELD_W = 5;
  localparam int OUT_COUNT_W  = 24;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // register indexes on the configuration port
  localparam logic REG_CATEGORIES = 1'b0;
  localparam logic REG_TIMES      = 1'b1;

  typedef struct packed {
    logic                  rd;
    logic                  wr;
    logic [ADDR_W-1:0]     addr;
    logic [COUNT_BITS-1:0] wdata;
  } pccc_req_t;

  typedef struct packed {
    logic                  valid;
    logic [COUNT_BITS-1:0] count;
    logic                  saturated;
  } pccc_result_t;

  typedef struct packed {
    logic busy;
    logic clearing;
  } pccc_status_t;

  function automatic logic [VAL_W-1:0] eff_categories(input logic [CFG_W-1:0] v);
    logic [VAL_W-1:0] r;
    if (v == CFG_W'(0)) r = VAL_W'(1);
    else if (int'(v) > MAX_CATEGORIES) r = VAL_W'(MAX_CATEGORIES);
    else r = VAL_W'(v);
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] eff_times(input logic [CFG_W-1:0] v);
    logic [VAL_W-1:0] r;
    if (int'(v) < 2) r = VAL_W'(2);
    else if (int'(v) > MAX_TIMES) r = VAL_W'(MAX_TIMES);
    else r = VAL_W'(v);
    return r;
  endfunction

  function automatic logic [PAIR_W-1:0] pair_total(input logic [VAL_W-1:0] t);
    logic [2*VAL_W-1:0] prod;
    prod = (2*VAL_W)'(t) * (2*VAL_W)'(t - VAL_W'(1));
    return PAIR_W'(prod >> 1);
  endfunction

  // c1, c2 one based, p one based
  function automatic logic [ADDR_W-1:0] table_index(input logic [CAT_FIELD_W-1:0] c1,
                                                     input logic [CAT_FIELD_W-1:0] c2,
                                                     input logic [PAIR_W-1:0] p);
    logic [ADDR_W-1:0] cc;
    cc = ADDR_W'(c1 - CAT_FIELD_W'(1)) * ADDR_W'(MAX_CATEGORIES)
         + ADDR_W'(c2 - CAT_FIELD_W'(1));
    return cc * ADDR_W'(MAX_PAIRS) + ADDR_W'(p - PAIR_W'(1));
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
  endfunction

endpackage

>>> sv/pccc_count_store.sv
// Count table memory: one access a cycle, registered read data.
module pccc_count_store (
  input  logic                            clk,
  input  pccc_pkg::pccc_req_t             req,
  output logic [pccc_pkg::COUNT_BITS-1:0] rdata
);
  import pccc_pkg::*;

  logic [COUNT_BITS-1:0] mem [TABLE_SIZE];
  logic [COUNT_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk) begin
    if (req.rd) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/pccc_ctrl.sv
// Sequencer: subject row store, pair walk, shared address and increment unit.
module pccc_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [pccc_pkg::CFG_W-1:0]        cat_cfg,
  input  logic [pccc_pkg::CFG_W-1:0]        time_cfg,
  input  logic                              accept,
  input  logic                              mode,
  input  logic [pccc_pkg::TIME_FIELD_W-1:0] time_index,
  input  logic [pccc_pkg::CAT_FIELD_W-1:0]  response,
  input  logic                              last_of_subject,
  input  logic [pccc_pkg::CAT_FIELD_W-1:0]  read_cat_first,
  input  logic [pccc_pkg::CAT_FIELD_W-1:0]  read_cat_second,
  input  logic [pccc_pkg::PAIR_FIELD_W-1:0] read_pair,
  input  logic                              out_free,
  input  logic [pccc_pkg::COUNT_BITS-1:0]   mem_rdata,
  output pccc_pkg::pccc_req_t               mem_req,
  output pccc_pkg::pccc_result_t            res,
  output pccc_pkg::pccc_status_t            status
);
  import pccc_pkg::*;

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_LOADA    = 3'd2;
  localparam logic [2:0] S_PAIR     = 3'd3;
  localparam logic [2:0] S_RMW      = 3'd4;
  localparam logic [2:0] S_RD_ISSUE = 3'd5;
  localparam logic [2:0] S_RD_WAIT  = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic [CAT_FIELD_W-1:0] row_r [MAX_TIMES];
  logic [CAT_FIELD_W-1:0] row_nxt [MAX_TIMES];
  logic [TIME_IDX_W-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [PAIR_W-1:0]      pair_r, pair_nxt;
  logic [CAT_FIELD_W-1:0] a_r, a_nxt;
  logic [ADDR_W-1:0]      clr_r, clr_nxt;
  logic [CAT_FIELD_W-1:0] op_c1_r, op_c1_nxt, op_c2_r, op_c2_nxt;
  logic [PAIR_W-1:0]      op_p_r, op_p_nxt;
  logic                   rd_ok_r, rd_ok_nxt;

  logic [VAL_W-1:0]       cats_eff, times_eff;
  logic [PAIR_W-1:0]      pairs_eff;
  logic [CAT_FIELD_W-1:0] b_cat;
  logic [CAT_FIELD_W-1:0] u_c1, u_c2;
  logic [PAIR_W-1:0]      u_p;
  logic [ADDR_W-1:0]      u_addr;
  logic                   advance;

  assign cats_eff  = eff_categories(cat_cfg);
  assign times_eff = eff_times(time_cfg);
  assign pairs_eff = pair_total(times_eff);
  assign b_cat     = row_r[j_r];

  // shared address unit: pair walk or read item
  always_comb begin
    if (state_r == S_PAIR || state_r == S_RMW) begin
      u_c1 = a_r;
      u_c2 = b_cat;
      u_p  = pair_r;
    end else begin
      u_c1 = op_c1_r;
      u_c2 = op_c2_r;
      u_p  = op_p_r;
    end
  end

  assign u_addr = table_index(u_c1, u_c2, u_p);

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    pair_nxt  = pair_r;
    a_nxt     = a_r;
    clr_nxt   = clr_r;
    op_c1_nxt = op_c1_r;
    op_c2_nxt = op_c2_r;
    op_p_nxt  = op_p_r;
    rd_ok_nxt = rd_ok_r;
    advance   = 1'b0;
    mem_req   = '{rd: 1'b0, wr: 1'b0, addr: u_addr, wdata: sat_inc(mem_rdata)};
    res       = '{valid: 1'b0, count: '0, saturated: 1'b0};

    unique case (state_r)
      S_CLEAR: begin
        mem_req.wr    = 1'b1;
        mem_req.addr  = clr_r;
        mem_req.wdata = '0;
        if (clr_r == ADDR_W'(TABLE_SIZE - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (accept && !mode) begin
          if (time_index != TIME_FIELD_W'(0) && int'(time_index) <= int'(times_eff)) begin
            row_nxt[TIME_IDX_W'(time_index - TIME_FIELD_W'(1))] =
              (int'(response) > int'(cats_eff)) ? CAT_FIELD_W'(0) : response;
          end
          if (last_of_subject) begin
            i_nxt     = '0;
            j_nxt     = TIME_IDX_W'(1);
            pair_nxt  = PAIR_W'(1);
            state_nxt = S_LOADA;
          end
        end else if (accept) begin
          op_c1_nxt = read_cat_first;
          op_c2_nxt = read_cat_second;
          op_p_nxt  = PAIR_W'(read_pair);
          rd_ok_nxt = read_cat_first != CAT_FIELD_W'(0) &&
                      int'(read_cat_first) <= int'(cats_eff) &&
                      read_cat_second != CAT_FIELD_W'(0) &&
                      int'(read_cat_second) <= int'(cats_eff) &&
                      read_pair != PAIR_FIELD_W'(0) &&
                      int'(read_pair) <= int'(pairs_eff);
          state_nxt = S_RD_ISSUE;
        end
      end
      S_LOADA: begin
        a_nxt     = row_r[i_r];
        state_nxt = S_PAIR;
      end
      S_PAIR: begin
        if (a_r != CAT_FIELD_W'(0) && b_cat != CAT_FIELD_W'(0)) begin
          mem_req.rd = 1'b1;
          state_nxt  = S_RMW;
        end else begin
          advance = 1'b1;
        end
      end
      S_RMW: begin
        mem_req.wr = 1'b1;
        advance    = 1'b1;
      end
      S_RD_ISSUE: begin
        mem_req.rd = rd_ok_r;
        state_nxt  = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        if (out_free) begin
          res.valid     = 1'b1;
          res.count     = rd_ok_r ? mem_rdata : '0;
          res.saturated = rd_ok_r && (mem_rdata == COUNT_MAX);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // step to the next time pair, or close the subject
    if (advance) begin
      pair_nxt = pair_r + PAIR_W'(1);
      if (int'(j_r) + 1 < int'(times_eff)) begin
        j_nxt     = j_r + TIME_IDX_W'(1);
        state_nxt = S_PAIR;
      end else if (int'(i_r) + 2 < int'(times_eff)) begin
        i_nxt     = i_r + TIME_IDX_W'(1);
        j_nxt     = i_r + TIME_IDX_W'(2);
        state_nxt = S_LOADA;
      end else begin
        for (int k = 0; k < MAX_TIMES; k++) begin
          row_nxt[k] = '0;
        end
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
      pair_r  <= '0;
      rd_ok_r <= 1'b0;
      for (int k = 0; k < MAX_TIMES; k++) begin
        row_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      pair_r  <= pair_nxt;
      rd_ok_r <= rd_ok_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    op_c1_r <= op_c1_nxt;
    op_c2_r <= op_c2_nxt;
    op_p_r  <= op_p_nxt;
  end

  assign status.busy     = (state_r != S_IDLE);
  assign status.clearing = (state_r == S_CLEAR);

endmodule

>>> sv/pairwise_category_cooccurrence_counter_top.sv
// Top level: configuration registers, sequencer, count table and result register.
//
// Counts, per time pair i<j and per category pair, how many subjects gave
// those two responses. A response record that does not close a subject does
// not stall the input. A read item passes through the read issue and read
// wait states and the count table's registered read port, and waits in the
// read wait state while the result register is still stalled. The record that
// closes a subject starts a walk over all time pairs for times_used = t: each
// earlier time point first loads its response (t-1 in all), then each of its
// pairs is visited, and each pair with both responses present has its count
// read, incremented with saturation and written back over the single table
// port. After reset the count table is zeroed one entry a cycle, all 1792
// entries, during which no item is accepted; configuration writes are taken at any time.
module pairwise_category_cooccurrence_counter_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [pccc_pkg::TIME_FIELD_W-1:0] in_time_index,
  input  logic [pccc_pkg::CAT_FIELD_W-1:0]  in_response,
  input  logic                              in_last_of_subject,
  input  logic [pccc_pkg::CAT_FIELD_W-1:0]  in_read_cat_first,
  input  logic [pccc_pkg::CAT_FIELD_W-1:0]  in_read_cat_second,
  input  logic [pccc_pkg::PAIR_FIELD_W-1:0] in_read_pair,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pccc_pkg::OUT_COUNT_W-1:0]  out_count,
  output logic                              out_saturated,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [pccc_pkg::APB_ADDR_W-1:0]   cfg_paddr,
  input  logic [pccc_pkg::APB_DATA_W-1:0]   cfg_pwdata,
  output logic [pccc_pkg::APB_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import pccc_pkg::*;

  `include "pairwise_category_cooccurrence_counter_top_defines.svh"

  logic [CFG_W-1:0]       cat_cfg_r, times_cfg_r;
  logic                   cfg_wr;
  logic                   accept;
  logic                   out_free;
  logic                   out_valid_r;
  logic [OUT_COUNT_W-1:0] out_count_r;
  logic                   out_saturated_r;
  logic [COUNT_BITS-1:0]  mem_rdata;
  pccc_req_t              mem_req;
  pccc_result_t           res;
  pccc_status_t           status;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cat_cfg_r   <= CFG_W'(8);
      times_cfg_r <= CFG_W'(8);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_CATEGORIES: cat_cfg_r   <= cfg_pwdata[CFG_W-1:0];
        REG_TIMES:      times_cfg_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_CATEGORIES: cfg_prdata = APB_DATA_W'(cat_cfg_r);
      REG_TIMES:      cfg_prdata = APB_DATA_W'(times_cfg_r);
      default:        cfg_prdata = '0;
    endcase
  end

  assign in_stall = status.busy;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  pccc_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cat_cfg         (cat_cfg_r),
    .time_cfg        (times_cfg_r),
    .accept          (accept),
    .mode            (in_mode),
    .time_index      (in_time_index),
    .response        (in_response),
    .last_of_subject (in_last_of_subject),
    .read_cat_first  (in_read_cat_first),
    .read_cat_second (in_read_cat_second),
    .read_pair       (in_read_pair),
    .out_free        (out_free),
    .mem_rdata       (mem_rdata),
    .mem_req         (mem_req),
    .res             (res),
    .status          (status)
  );

  pccc_count_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // result register: load a new beat, drop the old one once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_count_r     <= OUT_COUNT_W'(res.count);
      out_saturated_r <= res.saturated;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_count     = out_count_r;
  assign out_saturated = out_saturated_r;

  `PCCC_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, status.clearing, in_stall, "item taken while table is being cleared")
  `PCCC_ASSERT_IMP(a_result_into_free_reg, clk, rst_n, res.valid, out_free, "result overwrote a stalled beat")
  `PCCC_ASSERT_IMP(a_rmw_same_addr, clk, rst_n, mem_req.wr && !status.clearing, $past(mem_req.rd) && (mem_req.addr == $past(mem_req.addr)), "count write without matching read")
  `PCCC_ASSERT_NEXT(a_read_busy, clk, rst_n, accept && in_mode, in_stall, "read item did not hold the input side")

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the pairwise category co-occurrence counter.
`timescale 1ns / 1ps

module testbench;
  import pccc_pkg::*;

  typedef struct {
    logic                    mode;
    logic [TIME_FIELD_W-1:0] time_idx;
    logic [CAT_FIELD_W-1:0]  resp;
    logic                    last;
    logic [CAT_FIELD_W-1:0]  cat_a;
    logic [CAT_FIELD_W-1:0]  cat_b;
    logic [PAIR_FIELD_W-1:0] pair;
  } beat_t;

  typedef struct {
    logic [OUT_COUNT_W-1:0] count;
    logic                   sat;
  } count_result_t;

  typedef struct {
    beat_t                  beat;
    bit                     pinned;
    logic [OUT_COUNT_W-1:0] pinned_count;
  } plan_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_mode;
  logic [TIME_FIELD_W-1:0] in_time_index;
  logic [CAT_FIELD_W-1:0]  in_response;
  logic                    in_last_of_subject;
  logic [CAT_FIELD_W-1:0]  in_read_cat_first;
  logic [CAT_FIELD_W-1:0]  in_read_cat_second;
  logic [PAIR_FIELD_W-1:0] in_read_pair;
  logic                    out_valid;
  logic                    out_stall;
  logic [OUT_COUNT_W-1:0]  out_count;
  logic                    out_saturated;
  logic                    cfg_psel;
  logic                    cfg_penable;
  logic                    cfg_pwrite;
  logic [APB_ADDR_W-1:0]   cfg_paddr;
  logic [APB_DATA_W-1:0]   cfg_pwdata;
  logic [APB_DATA_W-1:0]   cfg_prdata;
  logic                    cfg_pready;

  pairwise_category_cooccurrence_counter_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_time_index      (in_time_index),
    .in_response        (in_response),
    .in_last_of_subject (in_last_of_subject),
    .in_read_cat_first  (in_read_cat_first),
    .in_read_cat_second (in_read_cat_second),
    .in_read_pair       (in_read_pair),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_count          (out_count),
    .out_saturated      (out_saturated),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  // register copies and the count table as the block should hold them
  logic [CFG_W-1:0]       cfg_cats;
  logic [CFG_W-1:0]       cfg_times;
  logic [CAT_FIELD_W-1:0] row_cat [MAX_TIMES];
  logic [COUNT_BITS-1:0]  tally [TABLE_SIZE];

  count_result_t pending_counts [$];
  count_result_t want;
  plan_row_t     plan [$];

  int  mismatches;
  int  beats_sent;
  int  records_sent;
  int  reads_sent;
  int  reads_checked;
  int  subjects_closed;
  int  settings_used;
  bit  quiet_spell;

  logic [CFG_W-1:0] cats_plan  [6] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd6};
  logic [CFG_W-1:0] times_plan [6] = '{4'd2, 4'd8, 4'd1, 4'd12, 4'd5, 4'd3};

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #3_000_000;
    $display("FAIL pairwise_category_cooccurrence_counter_top");
    $finish;
  end

  function automatic int unsigned cats_in_force();
    if (cfg_cats < 1) return 1;
    if (cfg_cats > MAX_CATEGORIES) return MAX_CATEGORIES;
    return cfg_cats;
  endfunction

  function automatic int unsigned times_in_force();
    if (cfg_times < 2) return 2;
    if (cfg_times > MAX_TIMES) return MAX_TIMES;
    return cfg_times;
  endfunction

  function automatic int unsigned slot_of(int unsigned c1, int unsigned c2, int unsigned p);
    return ((c1 - 1) * MAX_CATEGORIES + (c2 - 1)) * MAX_PAIRS + (p - 1);
  endfunction

  // walk every time pair i<j of the closed subject and bump the count of each pair with both responses present
  function automatic void fold_subject();
    int unsigned t;
    int unsigned pair;
    int unsigned at;
    t = times_in_force();
    pair = 0;
    for (int i = 0; i < t - 1; i++) begin
      for (int j = i + 1; j < t; j++) begin
        pair++;
        if (row_cat[i] != 0 && row_cat[j] != 0) begin
          at = slot_of(row_cat[i], row_cat[j], pair);
          if (at < TABLE_SIZE && tally[at] != COUNT_MAX) tally[at] = tally[at] + 1'b1;
        end
      end
    end
    for (int k = 0; k < MAX_TIMES; k++) row_cat[k] = '0;
  endfunction

  function automatic void take_record(beat_t b);
    logic [CAT_FIELD_W-1:0] r;
    r = (b.resp > cats_in_force()) ? '0 : b.resp;
    if (b.time_idx >= 1 && b.time_idx <= times_in_force()) row_cat[b.time_idx - 1] = r;
    if (b.last) begin
      fold_subject();
      subjects_closed++;
    end
  endfunction

  function automatic count_result_t look_up(beat_t b);
    count_result_t r;
    int unsigned   cats;
    int unsigned   t;
    int unsigned   at;
    r.count = '0;
    r.sat = 1'b0;
    cats = cats_in_force();
    t = times_in_force();
    if (b.cat_a >= 1 && b.cat_a <= cats && b.cat_b >= 1 && b.cat_b <= cats &&
        b.pair >= 1 && b.pair <= t * (t - 1) / 2) begin
      at = slot_of(b.cat_a, b.cat_b, b.pair);
      if (at < TABLE_SIZE) begin
        r.count = OUT_COUNT_W'(tally[at]);
        r.sat = (tally[at] == COUNT_MAX);
      end
    end
    return r;
  endfunction

  function automatic int unsigned pause_len();
    return quiet_spell ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic beat_t noise_beat();
    beat_t b;
    b.mode = 1'($urandom_range(0, 1));
    b.time_idx = TIME_FIELD_W'($urandom_range(0, 15));
    b.resp = CAT_FIELD_W'($urandom_range(0, 15));
    b.last = 1'($urandom_range(0, 1));
    b.cat_a = CAT_FIELD_W'($urandom_range(0, 15));
    b.cat_b = CAT_FIELD_W'($urandom_range(0, 15));
    b.pair = PAIR_FIELD_W'($urandom_range(0, 31));
    return b;
  endfunction

  function automatic plan_row_t rec_row(int unsigned t, int unsigned r, bit last);
    plan_row_t p;
    p.beat = noise_beat();
    p.beat.mode = 1'b0;
    p.beat.time_idx = TIME_FIELD_W'(t);
    p.beat.resp = CAT_FIELD_W'(r);
    p.beat.last = last;
    p.pinned = 1'b0;
    p.pinned_count = '0;
    return p;
  endfunction

  function automatic plan_row_t read_row(int unsigned c1, int unsigned c2, int unsigned pr,
                                         bit pinned, int unsigned cnt);
    plan_row_t p;
    p.beat = noise_beat();
    p.beat.mode = 1'b1;
    p.beat.cat_a = CAT_FIELD_W'(c1);
    p.beat.cat_b = CAT_FIELD_W'(c2);
    p.beat.pair = PAIR_FIELD_W'(pr);
    p.pinned = pinned;
    p.pinned_count = OUT_COUNT_W'(cnt);
    return p;
  endfunction

  task automatic drive_beat(input beat_t b);
    int unsigned gap;
    gap = pause_len();
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode = b.mode;
    in_time_index = b.time_idx;
    in_response = b.resp;
    in_last_of_subject = b.last;
    in_read_cat_first = b.cat_a;
    in_read_cat_second = b.cat_b;
    in_read_pair = b.pair;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic issue(input beat_t b, input bit pinned, input logic [OUT_COUNT_W-1:0] cnt);
    count_result_t r;
    drive_beat(b);
    beats_sent++;
    if (b.mode) begin
      reads_sent++;
      r = look_up(b);
      if (pinned) begin
        r.count = cnt;
        r.sat = 1'b0;
      end
      pending_counts.push_back(r);
    end else begin
      records_sent++;
      take_record(b);
    end
  endtask

  task automatic random_read();
    beat_t       b;
    int unsigned cats;
    int unsigned t;
    b = noise_beat();
    b.mode = 1'b1;
    cats = cats_in_force();
    t = times_in_force();
    if ($urandom_range(0, 4) != 0) begin
      b.cat_a = CAT_FIELD_W'($urandom_range(1, cats));
      b.cat_b = CAT_FIELD_W'($urandom_range(1, cats));
      b.pair = PAIR_FIELD_W'($urandom_range(1, t * (t - 1) / 2));
    end
    issue(b, 1'b0, '0);
  endtask

  // one subject: its time points in random order, some dropped, some stray
  task automatic random_subject();
    beat_t       b;
    int unsigned order [MAX_TIMES];
    int unsigned t;
    int unsigned cats;
    int unsigned n;
    int unsigned j;
    int unsigned tmp;
    int unsigned pick;
    t = times_in_force();
    cats = cats_in_force();
    for (int k = 0; k < MAX_TIMES; k++) order[k] = k + 1;
    for (int k = t - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, t) : t;
    for (int k = 0; k < n; k++) begin
      b = noise_beat();
      b.mode = 1'b0;
      b.time_idx = TIME_FIELD_W'(order[k]);
      if ($urandom_range(0, 19) == 0) b.time_idx = TIME_FIELD_W'($urandom_range(0, 15));
      pick = $urandom_range(0, 19);
      if (pick < 15) b.resp = CAT_FIELD_W'($urandom_range(1, cats));
      else if (pick < 17) b.resp = '0;
      else b.resp = CAT_FIELD_W'($urandom_range(0, 15));
      b.last = (k == n - 1);
      issue(b, 1'b0, '0);
      if ($urandom_range(0, 9) == 0) random_read();
    end
  endtask

  // hold until every count is back and the last walk has finished
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = APB_ADDR_W'({reg_idx, 2'b00});
    cfg_pwdata = ($urandom & 32'hFFFF_FFF0) | APB_DATA_W'(val);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (reg_idx == REG_CATEGORIES) cfg_cats = val;
    else cfg_times = val;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  // result side: draw a stall spell per beat, then wait for the beat
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      hold = pause_len();
      if (hold != 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: count beat with nothing expected: count %0d saturated %0b",
                 $time, out_count, out_saturated);
        mismatches++;
      end else begin
        want = pending_counts.pop_front();
        reads_checked++;
        if (out_count !== want.count) begin
          $display("%0t: count expected %0d, got %0d", $time, want.count, out_count);
          mismatches++;
        end
        if (out_saturated !== want.sat) begin
          $display("%0t: saturated expected %0b, got %0b", $time, want.sat, out_saturated);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned stop;
    int unsigned pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = 1'b0;
    in_time_index = '0;
    in_response = '0;
    in_last_of_subject = 1'b0;
    in_read_cat_first = '0;
    in_read_cat_second = '0;
    in_read_pair = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cfg_cats = 4'd8;
    cfg_times = 4'd8;
    quiet_spell = 1'b0;
    for (int k = 0; k < MAX_TIMES; k++) row_cat[k] = '0;
    for (int k = 0; k < TABLE_SIZE; k++) tally[k] = '0;

    // empty table, extreme and out-of-range reads
    plan.push_back(read_row(1, 1, 1, 1'b1, 0));
    plan.push_back(read_row(8, 8, 28, 1'b1, 0));
    plan.push_back(read_row(0, 1, 1, 1'b1, 0));
    plan.push_back(read_row(1, 9, 1, 1'b1, 0));
    plan.push_back(read_row(1, 1, 0, 1'b1, 0));
    plan.push_back(read_row(1, 1, 29, 1'b1, 0));
    plan.push_back(read_row(15, 15, 31, 1'b1, 0));
    // one subject with a gap, a stray category, stray times and a repeated time
    plan.push_back(rec_row(1, 1, 1'b0));
    plan.push_back(rec_row(2, 8, 1'b0));
    plan.push_back(rec_row(3, 0, 1'b0));
    plan.push_back(rec_row(8, 15, 1'b0));
    plan.push_back(rec_row(0, 3, 1'b0));
    plan.push_back(rec_row(15, 5, 1'b0));
    plan.push_back(rec_row(2, 2, 1'b0));
    plan.push_back(rec_row(4, 3, 1'b1));
    plan.push_back(read_row(1, 2, 1, 1'b0, 0));
    plan.push_back(read_row(1, 8, 1, 1'b0, 0));
    plan.push_back(read_row(1, 3, 3, 1'b0, 0));
    plan.push_back(read_row(2, 3, 9, 1'b0, 0));
    plan.push_back(read_row(2, 3, 1, 1'b0, 0));
    // subject closed with nothing stored
    plan.push_back(rec_row(0, 0, 1'b1));
    plan.push_back(read_row(1, 2, 1, 1'b0, 0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    settings_used = 1;

    foreach (plan[k]) issue(plan[k].beat, plan[k].pinned, plan[k].pinned_count);

    for (int ph = 0; ph <= 6; ph++) begin
      if (ph > 0) begin
        settle();
        write_reg(REG_CATEGORIES, cats_plan[ph - 1]);
        write_reg(REG_TIMES, times_plan[ph - 1]);
        settings_used++;
      end
      stop = beats_sent + 185;
      while (beats_sent < stop) begin
        quiet_spell = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 19);
        if (pick == 0) issue(noise_beat(), 1'b0, '0);
        else if (pick < 4) random_read();
        else begin
          random_subject();
          repeat ($urandom_range(0, 2)) random_read();
        end
      end
    end

    quiet_spell = 1'b0;
    settle();
    $display("Covered %0d records over %0d subject closes and %0d count reads (%0d checked)",
             records_sent, subjects_closed, reads_sent, reads_checked);
    $display("under %0d register settings, with random stalls on both channels",
             settings_used);
    if (mismatches == 0) begin
      $display("PASS pairwise_category_cooccurrence_counter_top");
    end else begin
      $display("FAIL pairwise_category_cooccurrence_counter_top");
    end
    $finish;
  end

endmodule

>>> pairwise_category_cooccurrence_counter_top.f
+incdir+sv
sv/pccc_pkg.sv
sv/pccc_count_store.sv
sv/pccc_ctrl.sv
sv/pairwise_category_cooccurrence_counter_top.sv
tb/testbench.sv
